/* src/cone_max_filter_unit_defines.svh */
// assertion macros for the cone max filter unit
// used by the top level only; needs clock and reset in the including scope
`ifndef CONE_MAX_FILTER_UNIT_DEFINES_SVH
`define CONE_MAX_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define CMF_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cmf check failed");
`define CMF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cmf check failed");
`else
`define CMF_ASSERT_IMPLY(lbl, ante, cons)
`define CMF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* src/cmf_pkg.sv */
// shared constants for the cone max filter unit
// no dependencies
package cmf_pkg;

   localparam int DEFAULT_MAX_SIZE   = 64;
   localparam int DEFAULT_DATA_WIDTH = 16;

   // configuration register file
   localparam int CFG_SIZE_W      = 7;
   localparam int CSR_ADDR_W      = 3;
   localparam int CSR_DATA_W      = 32;
   localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = 7'd64;

   typedef enum logic [0:0] {
      REG_MATRIX_SIZE = 1'b0
   } reg_index_type;

endpackage

/* src/cone_max_filter_unit.sv */
// cone max filter top level: register port, cone core and result buffer
// depends on cmf_pkg, cmf_cone_core, cmf_out_skid and the defines header
//
// Streams the elements of a square signed matrix in raster order and returns,
// for each, the maximum over the upward triangular cone ending at it, using
// B[i][j] = max(A[i][j], B[i-1][j-1..j+1]). One word is taken every clock
// cycle while req_stall is low; its result is registered on acceptance.
// The rate is set by the line store (MAX_SIZE words of DATA_WIDTH bits), which
// is written once and read at two addresses per word, fetching two columns
// ahead so the max sees a three-word window of the row above. A one-word skid
// behind the result register keeps input acceptance going while a result
// waits. Writing matrix_size (register 0) restarts the raster at row 0,
// column 0; a size of 0 acts as 1 and sizes above MAX_SIZE act as MAX_SIZE.
`include "cone_max_filter_unit_defines.svh"

module cone_max_filter_unit #(
   parameter int MAX_SIZE   = cmf_pkg::DEFAULT_MAX_SIZE,
   parameter int DATA_WIDTH = cmf_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   // input words
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [DATA_WIDTH-1:0]   req_sample,
   // result words
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [DATA_WIDTH-1:0]   rsp_cone_max,
   output logic                           rsp_last_of_matrix,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cmf_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cmf_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cmf_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   logic [cmf_pkg::CFG_SIZE_W-1:0] size_ff;
   logic                           size_wr;
   logic                           in_fire;
   logic                           skid_full;
   logic signed [DATA_WIDTH-1:0]   core_max;
   logic                           core_last;

   assign csr_pready = 1'b1;
   assign size_wr    = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (cmf_pkg::reg_index_type'(csr_paddr[2]) == cmf_pkg::REG_MATRIX_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= cmf_pkg::SIZE_RESET;
      end else if (size_wr) begin
         size_ff <= csr_pwdata[cmf_pkg::CFG_SIZE_W-1:0];
      end
   end

   always_comb begin
      unique case (cmf_pkg::reg_index_type'(csr_paddr[2]))
         cmf_pkg::REG_MATRIX_SIZE: csr_prdata = cmf_pkg::CSR_DATA_W'(size_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   assign in_fire   = req_valid && !req_stall;
   assign req_stall = skid_full;

   cmf_cone_core #(
      .MAX_SIZE   (MAX_SIZE),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .restart      (size_wr),
      .matrix_size  (size_ff),
      .in_fire      (in_fire),
      .in_sample    (req_sample),
      .out_cone_max (core_max),
      .out_last     (core_last)
   );

   cmf_out_skid #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .in_fire   (in_fire),
      .in_data   (core_max),
      .in_last   (core_last),
      .full      (skid_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_cone_max),
      .out_last  (rsp_last_of_matrix)
   );

   // a full skid word always has a result in front of it
   `CMF_ASSERT_IMPLY(a_stall_has_result, req_stall, rsp_valid)
   // after an accepted word the output always holds a valid result next cycle
   `CMF_ASSERT_NEXT(a_accept_gives_result, in_fire, rsp_valid)
   // the skid only fills while the result side is stalling
   `CMF_ASSERT_IMPLY(a_skid_fill_cause, $rose(req_stall), $past(rsp_stall) && $past(rsp_valid))

endmodule

/* src/cmf_line_store.sv */
// line store holding the previous output row
// two registered read ports, one write port, write-through on address match
module cmf_line_store #(
   parameter int DEPTH      = cmf_pkg::DEFAULT_MAX_SIZE,
   parameter int DATA_WIDTH = cmf_pkg::DEFAULT_DATA_WIDTH,
   parameter int ADDR_W     = 6
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [ADDR_W-1:0]     wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [ADDR_W-1:0]     rd_a_addr,
   input  logic [ADDR_W-1:0]     rd_b_addr,
   output logic [DATA_WIDTH-1:0] rd_a_data,
   output logic [DATA_WIDTH-1:0] rd_b_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_a_ff;
   logic [DATA_WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         mem[wr_addr] <= wr_data;
         // the word written now is the one wanted next for tiny sizes
         rd_a_ff <= (wr_addr == rd_a_addr) ? wr_data : mem[rd_a_addr];
         rd_b_ff <= (wr_addr == rd_b_addr) ? wr_data : mem[rd_b_addr];
      end
   end

   assign rd_a_data = rd_a_ff;
   assign rd_b_data = rd_b_ff;

endmodule

/* src/cmf_cone_core.sv */
// raster position tracking, three-word window over the row above and the max
// depends on cmf_pkg and cmf_line_store
module cmf_cone_core #(
   parameter int MAX_SIZE   = cmf_pkg::DEFAULT_MAX_SIZE,
   parameter int DATA_WIDTH = cmf_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic [cmf_pkg::CFG_SIZE_W-1:0] matrix_size,
   input  logic                           in_fire,
   input  logic signed [DATA_WIDTH-1:0]   in_sample,
   output logic signed [DATA_WIDTH-1:0]   out_cone_max,
   output logic                           out_last
);

   localparam int IDX_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
   localparam int SIZE_W = $clog2(MAX_SIZE + 1);
   localparam int RB_IDX = (MAX_SIZE > 1) ? 1 : 0;

   logic [SIZE_W-1:0]  size_n;
   logic [IDX_W-1:0]   col_ff, col_in, row_ff, row_in;
   logic               wrap_ff, wrap_in;
   logic signed [DATA_WIDTH-1:0] left_ff, left_in, above_ff, above_in;
   logic signed [DATA_WIDTH-1:0] rd_a, rd_b, above_cur, right_cur, best;
   logic [SIZE_W:0]    size_x, col_p1, col_p2, row_p1;
   logic               last_col, last_row, has_right;
   logic [IDX_W-1:0]   rd_a_addr;

   always_comb begin
      if (matrix_size == '0) begin
         size_n = SIZE_W'(1);
      end else if (32'(matrix_size) > 32'(MAX_SIZE)) begin
         size_n = SIZE_W'(MAX_SIZE);
      end else begin
         size_n = SIZE_W'(matrix_size);
      end
   end

   assign size_x    = {1'b0, size_n};
   assign col_p1    = (SIZE_W+1)'(col_ff) + (SIZE_W+1)'(1);
   assign col_p2    = (SIZE_W+1)'(col_ff) + (SIZE_W+1)'(2);
   assign row_p1    = (SIZE_W+1)'(row_ff) + (SIZE_W+1)'(1);
   assign last_col  = (col_p1 == size_x);
   assign last_row  = (row_p1 == size_x);
   assign has_right = (col_p1 < size_x);

   // right after a row wrap the window comes from the two first store words
   assign above_cur = wrap_ff ? rd_a : above_ff;
   assign right_cur = wrap_ff ? rd_b : rd_a;

   always_comb begin
      best = in_sample;
      if (row_ff != '0) begin
         if (above_cur > best) begin
            best = above_cur;
         end
         if ((col_ff != '0) && (left_ff > best)) begin
            best = left_ff;
         end
         if (has_right && (right_cur > best)) begin
            best = right_cur;
         end
      end
   end

   always_comb begin
      left_in  = above_cur;
      above_in = right_cur;
      wrap_in  = last_col;
      if (last_col) begin
         col_in = '0;
         row_in = last_row ? '0 : row_p1[IDX_W-1:0];
      end else begin
         col_in = col_p1[IDX_W-1:0];
         row_in = row_ff;
      end
      // fetch two columns ahead, or column 0 (for the coming row) once that runs past the row end
      if (last_col || (col_p2 >= size_x)) begin
         rd_a_addr = '0;
      end else begin
         rd_a_addr = col_p2[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff  <= '0;
         row_ff  <= '0;
         wrap_ff <= 1'b0;
      end else if (in_fire) begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         wrap_ff <= wrap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_fire) begin
         left_ff  <= left_in;
         above_ff <= above_in;
      end
   end

   cmf_line_store #(
      .DEPTH      (MAX_SIZE),
      .DATA_WIDTH (DATA_WIDTH),
      .ADDR_W     (IDX_W)
   ) u_line_store (
      .clock     (clock),
      .enable    (in_fire),
      .wr_addr   (col_ff),
      .wr_data   (best),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (IDX_W'(RB_IDX)),
      .rd_a_data (rd_a),
      .rd_b_data (rd_b)
   );

   assign out_cone_max = best;
   assign out_last     = last_col && last_row;

endmodule

/* src/cmf_out_skid.sv */
// result register with one skid word behind it
// depends on cmf_pkg for defaults
module cmf_out_skid #(
   parameter int DATA_WIDTH = cmf_pkg::DEFAULT_DATA_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_fire,
   input  logic [DATA_WIDTH-1:0] in_data,
   input  logic                  in_last,
   output logic                  full,
   output logic                  out_valid,
   input  logic                  out_stall,
   output logic [DATA_WIDTH-1:0] out_data,
   output logic                  out_last
);

   logic                  main_v_ff, main_v_in, skid_v_ff, skid_v_in;
   logic [DATA_WIDTH-1:0] main_d_ff, main_d_in, skid_d_ff;
   logic                  main_l_ff, main_l_in, skid_l_ff;
   logic                  take, to_skid;

   assign take    = main_v_ff && !out_stall;
   assign to_skid = in_fire && main_v_ff && !take;

   always_comb begin
      main_v_in = main_v_ff;
      skid_v_in = skid_v_ff;
      main_d_in = main_d_ff;
      main_l_in = main_l_ff;
      if (in_fire && (!main_v_ff || take)) begin
         main_v_in = 1'b1;
         main_d_in = in_data;
         main_l_in = in_last;
      end else if (to_skid) begin
         skid_v_in = 1'b1;
      end else if (take && skid_v_ff) begin
         main_d_in = skid_d_ff;
         main_l_in = skid_l_ff;
         skid_v_in = 1'b0;
      end else if (take) begin
         main_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         main_v_ff <= main_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      main_d_ff <= main_d_in;
      main_l_ff <= main_l_in;
      if (to_skid) begin
         skid_d_ff <= in_data;
         skid_l_ff <= in_last;
      end
   end

   assign full      = skid_v_ff;
   assign out_valid = main_v_ff;
   assign out_data  = main_d_ff;
   assign out_last  = main_l_ff;

endmodule
